// ----- hdl/fqip_pkg.sv -----
package fqip_pkg;

  localparam int unsigned Depth     = 16;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned IdxWidth  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth  = $clog2(Depth + 1);

  typedef enum logic [2:0] {
    CMD_APPEND    = 3'd0,
    CMD_REMOVE    = 3'd1,
    CMD_GET_FIRST = 3'd2,
    CMD_GET_LAST  = 3'd3,
    CMD_GET_AT    = 3'd4,
    CMD_SIZE_DUMP = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_EMPTY      = 3'd1,
    STAT_INVALID    = 3'd2,
    STAT_FULL       = 3'd3,
    STAT_EMPTY_DUMP = 3'd4
  } status_e;

  typedef enum logic {
    FSM_IDLE,
    FSM_DUMP
  } state_e;

  typedef logic [IdxWidth-1:0] idx_t;
  typedef logic [CntWidth-1:0] cnt_t;

  // Ring buffer index arithmetic: (base + off) mod Depth, both below Depth.
  function automatic idx_t wrap_add(idx_t base, idx_t off);
    logic [IdxWidth:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IdxWidth + 1)'(Depth)) begin
      sum = sum - (IdxWidth + 1)'(Depth);
    end
    return sum[IdxWidth-1:0];
  endfunction

endpackage

// ----- hdl/fifo_queue_with_indexed_peek.sv -----
// A command is taken only while the block is idle, and its result beat appears in the cycle after.
// Single-result commands may be issued back to back, one per cycle.
// A dump of N elements gives N beats on consecutive cycles, one element store read each,
// and holds busy_o high while the beats after the first are read.
// Reset empties the queue; the element store itself is not cleared.
// Result beats last one cycle each and the receiver cannot stall them.
module fifo_queue_with_indexed_peek (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         cmd_i,
  input  logic signed [31:0] value_i,
  input  logic [15:0]        position_i,
  input  logic               dump_i,
  output logic               valid_o,
  output logic signed [31:0] data_o,
  output logic [6:0]         count_o,
  output logic [2:0]         status_o,
  output logic               last_o
);

  logic signed [fqip_pkg::DataWidth-1:0] mem [fqip_pkg::Depth];
  logic signed [fqip_pkg::DataWidth-1:0] rdata_q;

  fqip_pkg::state_e  state_q, state_d;
  fqip_pkg::idx_t    head_q, head_d;
  fqip_pkg::cnt_t    cnt_q, cnt_d;
  fqip_pkg::idx_t    dslot_q, dslot_d;
  fqip_pkg::idx_t    doff_q, doff_d;
  logic              valid_q, valid_d;
  logic              last_q, last_d;
  logic              rsel_q, rsel_d;
  fqip_pkg::status_e status_q, status_d;

  logic                                 mem_we;
  logic                                 mem_re;
  fqip_pkg::idx_t                       mem_waddr;
  fqip_pkg::idx_t                       mem_raddr;
  logic signed [fqip_pkg::DataWidth-1:0] mem_wdata;

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    cnt_d     = cnt_q;
    dslot_d   = dslot_q;
    doff_d    = doff_q;
    valid_d   = 1'b0;
    last_d    = 1'b1;
    rsel_d    = 1'b0;
    status_d  = fqip_pkg::STAT_OK;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = head_q;
    mem_raddr = head_q;
    mem_wdata = fqip_pkg::DataWidth'(value_i);

    unique case (state_q)
      fqip_pkg::FSM_IDLE: begin
        if (start_i) begin
          valid_d = 1'b1;
          unique case (cmd_i)
            fqip_pkg::CMD_APPEND: begin
              if (cnt_q == fqip_pkg::CntWidth'(fqip_pkg::Depth)) begin
                status_d = fqip_pkg::STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = fqip_pkg::wrap_add(head_q, fqip_pkg::IdxWidth'(cnt_q));
                cnt_d     = cnt_q + 1'b1;
              end
            end
            fqip_pkg::CMD_REMOVE: begin
              if (cnt_q == '0) begin
                status_d = fqip_pkg::STAT_EMPTY;
              end else begin
                mem_re = 1'b1;
                rsel_d = 1'b1;
                head_d = fqip_pkg::wrap_add(head_q, fqip_pkg::IdxWidth'(1));
                cnt_d  = cnt_q - 1'b1;
              end
            end
            fqip_pkg::CMD_GET_FIRST: begin
              if (cnt_q == '0) begin
                status_d = fqip_pkg::STAT_EMPTY;
              end else begin
                mem_re = 1'b1;
                rsel_d = 1'b1;
              end
            end
            fqip_pkg::CMD_GET_LAST: begin
              if (cnt_q == '0) begin
                status_d = fqip_pkg::STAT_EMPTY;
              end else begin
                mem_re    = 1'b1;
                rsel_d    = 1'b1;
                mem_raddr = fqip_pkg::wrap_add(head_q,
                                               fqip_pkg::IdxWidth'(cnt_q - 1'b1));
              end
            end
            fqip_pkg::CMD_GET_AT: begin
              if (position_i >= 16'(cnt_q)) begin
                status_d = fqip_pkg::STAT_INVALID;
              end else begin
                mem_re    = 1'b1;
                rsel_d    = 1'b1;
                mem_raddr = fqip_pkg::wrap_add(head_q,
                                               fqip_pkg::IdxWidth'(position_i));
              end
            end
            fqip_pkg::CMD_SIZE_DUMP: begin
              if (dump_i) begin
                if (cnt_q == '0) begin
                  status_d = fqip_pkg::STAT_EMPTY_DUMP;
                end else begin
                  mem_re = 1'b1;
                  rsel_d = 1'b1;
                  last_d = (cnt_q == fqip_pkg::CntWidth'(1));
                  if (cnt_q != fqip_pkg::CntWidth'(1)) begin
                    state_d = fqip_pkg::FSM_DUMP;
                    dslot_d = fqip_pkg::wrap_add(head_q, fqip_pkg::IdxWidth'(1));
                    doff_d  = fqip_pkg::IdxWidth'(1);
                  end
                end
              end
            end
            default: begin
              status_d = fqip_pkg::STAT_INVALID;
            end
          endcase
        end
      end
      fqip_pkg::FSM_DUMP: begin
        valid_d   = 1'b1;
        mem_re    = 1'b1;
        rsel_d    = 1'b1;
        mem_raddr = dslot_q;
        last_d    = (doff_q == fqip_pkg::IdxWidth'(cnt_q - 1'b1));
        dslot_d   = fqip_pkg::wrap_add(dslot_q, fqip_pkg::IdxWidth'(1));
        doff_d    = doff_q + 1'b1;
        if (last_d) begin
          state_d = fqip_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_d = fqip_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fqip_pkg::FSM_IDLE;
      head_q   <= '0;
      cnt_q    <= '0;
      dslot_q  <= '0;
      doff_q   <= '0;
      valid_q  <= 1'b0;
      last_q   <= 1'b0;
      rsel_q   <= 1'b0;
      status_q <= fqip_pkg::STAT_OK;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      cnt_q    <= cnt_d;
      dslot_q  <= dslot_d;
      doff_q   <= doff_d;
      valid_q  <= valid_d;
      last_q   <= last_d;
      rsel_q   <= rsel_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign busy_o   = (state_q == fqip_pkg::FSM_DUMP);
  assign valid_o  = valid_q;
  assign data_o   = rsel_q ? 32'(rdata_q) : '0;
  assign count_o  = 7'(cnt_q);
  assign status_o = status_q;
  assign last_o   = last_q;

  // Each accepted command yields a beat on the next cycle.
  a_beat_follows_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> valid_o)
    else $error("accepted command produced no result beat");

  // A dump in progress emits a beat every cycle.
  a_dump_streams: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> valid_o)
    else $error("dump stalled without a beat");

  // The final beat of a command leaves the block ready for the next one.
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |-> !busy_o)
    else $error("busy after final beat");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= fqip_pkg::CntWidth'(fqip_pkg::Depth))
    else $error("element count above depth");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o != fqip_pkg::STAT_OK) |-> (data_o == '0))
    else $error("nonzero data on error beat");

endmodule
